// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the RTL. Sampled on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition (may hold an implication) checked at every clock edge.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define CHK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/ut2bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// ut2bcd_pkg
// Constants, types and small helpers for the Unix time to BCD calendar
// converter.
// ----------------------------------------------------------------------------
package ut2bcd_pkg;

  localparam int unsigned NUM_STAGES    = 15;

  // time of day
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned DAY_RCP       = 32'((64'd1 << 32) / 64'(SEC_PER_DAY)); // k = 32
  localparam int unsigned HOUR_RCP      = (2**17) / SEC_PER_HOUR;  // k = 17
  localparam int unsigned MIN_RCP       = (2**12) / SEC_PER_MIN;   // k = 12

  // weekday: epoch day was a Thursday
  localparam int unsigned WDAY_OFS      = 4;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned WEEK_RCP      = (2**16) / DAYS_PER_WEEK; // k = 16

  // civil-from-days
  localparam int unsigned EPOCH_SHIFT   = 719468;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned ERA_LAST_DOE  = 146096;
  localparam int unsigned ERA_SPLIT     = 5 * DAYS_PER_ERA - EPOCH_SHIFT;
  localparam int unsigned DOE_OFS       = EPOCH_SHIFT - 4 * DAYS_PER_ERA;
  localparam int unsigned DAYS_PER_4Y   = 1460;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned Q4Y_RCP       = (2**18) / DAYS_PER_4Y;   // k = 18
  localparam int unsigned Q100Y_RCP     = (2**18) / DAYS_PER_100Y; // k = 18
  localparam int unsigned YEAR_RCP      = (2**18) / DAYS_PER_YEAR; // k = 18
  localparam int unsigned MP_DAYS       = 153;
  localparam int unsigned MP_RCP        = (2**11) / MP_DAYS;       // k = 11
  localparam int unsigned MONTHS_WRAP   = 10;
  localparam int unsigned YEAR_ERA4     = 1600;
  localparam int unsigned YEAR_ERA5     = 2000;
  localparam int unsigned YEAR_MIN      = 2000;
  localparam int unsigned YEAR_MAX      = 2099;
  localparam int unsigned YEAR_CENTURY  = 1900;

  // Time-of-day fields carried down the date pipeline.
  typedef struct packed {
    logic [4:0] hh;
    logic [5:0] mi;
    logic [5:0] ss;
    logic [2:0] wd;   // 0 = Sunday
  } tod_t;

  // (153 * mp + 2) / 5: day offset of each March-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // 0..99 to packed BCD; v * 205 >> 11 is exact v / 10 in this range
  function automatic logic [7:0] bin2bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  units;
    p     = 15'(v) * 15'(205);
    tens  = p[14:11];
    units = v - 7'(tens) * 7'(10);
    return {tens, units[3:0]};
  endfunction

endpackage

// ----- rtl/unix_time_to_bcd_calendar.sv -----
// ----------------------------------------------------------------------------
// unix_time_to_bcd_calendar
// Unix timestamp to packed-BCD real-time-clock register fields.
//
// Each input beat carries a 32-bit count of seconds since 1970-01-01 00:00:00
// UTC; each output beat carries second, minute, hour (24-hour form, bit 6
// clear), weekday (1 = Sunday .. 7 = Saturday), day, month and year as the
// packed-BCD values a clock chip takes, plus a flag set when the year lies
// outside 2000..2099 (year_bcd then holds the year modulo 100). There is
// exactly one output beat per input beat, in order. The block is a
// 15-stage pipeline that sustains one beat per clock while the output is
// not stalled. Stages hand over with their own valid bits, so a stalled
// output only holds back the stages behind it that are full; empty stages
// keep filling. The divisions by 86400, 3600, 60, 7, 1460, 36524, 365 and
// 153 are each done as a reciprocal multiply in one stage followed by a
// single compare-and-subtract fixup in the next, which sets the stage count.
// ----------------------------------------------------------------------------
module unix_time_to_bcd_calendar
  import ut2bcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] unix_seconds

  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] second_bcd, [13:7] minute_bcd, [19:14] hour_bcd, [22:20] weekday,
  // [28:23] day_bcd, [33:29] month_bcd, [41:34] year_bcd,
  // [42] year_out_of_range, [47:43] zero
  output logic [47:0] out_tdata
);

  localparam int unsigned LAST = NUM_STAGES - 1;

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  logic [LAST:0] v_r;
  logic [LAST:0] v_nxt;
  logic [LAST:0] en;

  always_comb begin
    en[LAST] = !v_r[LAST] || out_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int i = 1; i <= LAST; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[LAST];

  // --------------------------------------------------------------------------
  // Stage 0: estimate days = t / 86400 (may be one low).
  // --------------------------------------------------------------------------
  logic [31:0] t0_r;
  logic [15:0] dq0_r, dq0_nxt;
  logic [47:0] day_prod;

  assign day_prod = 48'(in_tdata) * 48'(DAY_RCP);
  assign dq0_nxt  = day_prod[47:32];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r  <= in_tdata;
      dq0_r <= dq0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: fix days, seconds of day.
  // --------------------------------------------------------------------------
  logic [15:0] days1_r, days1_nxt;
  logic [16:0] sod1_r, sod1_nxt;
  logic [31:0] day_sec;
  logic [17:0] sod_raw;
  logic        day_fix;

  assign day_sec   = 32'(dq0_r) * 32'(SEC_PER_DAY);
  assign sod_raw   = 18'(t0_r - day_sec);
  assign day_fix   = sod_raw >= 18'(SEC_PER_DAY);
  assign days1_nxt = dq0_r + 16'(day_fix);
  assign sod1_nxt  = 17'(day_fix ? sod_raw - 18'(SEC_PER_DAY) : sod_raw);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days1_r <= days1_nxt;
      sod1_r  <= sod1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: hour estimate; era and day of era; weekday estimate.
  // Every 32-bit timestamp falls in era 4 or era 5 (split at 2000-03-01).
  // --------------------------------------------------------------------------
  logic [16:0] sod2_r;
  logic [4:0]  hq0_r, hq0_nxt;
  logic        era2_r, era2_nxt;
  logic [17:0] doe2_r, doe2_nxt;
  logic [15:0] w2_r, w2_nxt;
  logic [12:0] wq0_r, wq0_nxt;
  logic [22:0] hour_prod;
  logic [31:0] week_prod;

  assign hour_prod = 23'(sod1_r) * 23'(HOUR_RCP);
  assign hq0_nxt   = hour_prod[21:17];
  assign era2_nxt  = days1_r >= 16'(ERA_SPLIT);
  assign doe2_nxt  = era2_nxt ? 18'(days1_r) - 18'(ERA_SPLIT)
                              : 18'(days1_r) + 18'(DOE_OFS);
  assign w2_nxt    = days1_r + 16'(WDAY_OFS);
  assign week_prod = 32'(w2_nxt) * 32'(WEEK_RCP);
  assign wq0_nxt   = week_prod[28:16];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sod2_r <= sod1_r;
      hq0_r  <= hq0_nxt;
      era2_r <= era2_nxt;
      doe2_r <= doe2_nxt;
      w2_r   <= w2_nxt;
      wq0_r  <= wq0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: fix hour; weekday; estimates of doe / 1460 and doe / 36524.
  // --------------------------------------------------------------------------
  logic [4:0]  hh3_r, hh3_nxt;
  logic [11:0] rem3_r, rem3_nxt;
  logic [2:0]  wd3_r, wd3_nxt;
  logic        era3_r;
  logic [17:0] doe3_r;
  logic [7:0]  q4y3_r, q4y3_nxt;
  logic [2:0]  q100y3_r, q100y3_nxt;
  logic        last3_r, last3_nxt;
  logic [12:0] hr_raw;
  logic        hr_fix;
  logic [3:0]  wr_raw;
  logic [25:0] q4y_prod;
  logic [20:0] q100y_prod;

  assign hr_raw     = 13'(sod2_r - 17'(hq0_r) * 17'(SEC_PER_HOUR));
  assign hr_fix     = hr_raw >= 13'(SEC_PER_HOUR);
  assign hh3_nxt    = hq0_r + 5'(hr_fix);
  assign rem3_nxt   = 12'(hr_fix ? hr_raw - 13'(SEC_PER_HOUR) : hr_raw);
  assign wr_raw     = 4'(w2_r - 16'(wq0_r) * 16'(DAYS_PER_WEEK));
  assign wd3_nxt    = 3'((wr_raw >= 4'(DAYS_PER_WEEK)) ? wr_raw - 4'(DAYS_PER_WEEK)
                                                      : wr_raw);
  assign q4y_prod   = 26'(doe2_r) * 26'(Q4Y_RCP);
  assign q4y3_nxt   = q4y_prod[25:18];
  assign q100y_prod = 21'(doe2_r) * 21'(Q100Y_RCP);
  assign q100y3_nxt = q100y_prod[20:18];
  assign last3_nxt  = doe2_r == 18'(ERA_LAST_DOE);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hh3_r    <= hh3_nxt;
      rem3_r   <= rem3_nxt;
      wd3_r    <= wd3_nxt;
      era3_r   <= era2_r;
      doe3_r   <= doe2_r;
      q4y3_r   <= q4y3_nxt;
      q100y3_r <= q100y3_nxt;
      last3_r  <= last3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: minute estimate; fix the leap-cycle quotients.
  // --------------------------------------------------------------------------
  logic [4:0]  hh4_r;
  logic [11:0] rem4_r;
  logic [6:0]  mq0_r, mq0_nxt;
  logic [2:0]  wd4_r;
  logic        era4_r;
  logic [17:0] doe4_r;
  logic [7:0]  a4_r, a4_nxt;
  logic [2:0]  b4_r, b4_nxt;
  logic        last4_r;
  logic [18:0] min_prod;
  logic [11:0] r4y;
  logic [16:0] r100y;

  assign min_prod = 19'(rem3_r) * 19'(MIN_RCP);
  assign mq0_nxt  = min_prod[18:12];
  assign r4y      = 12'(doe3_r - 18'(q4y3_r) * 18'(DAYS_PER_4Y));
  assign a4_nxt   = q4y3_r + 8'(r4y >= 12'(DAYS_PER_4Y));
  assign r100y    = 17'(doe3_r - 18'(q100y3_r) * 18'(DAYS_PER_100Y));
  assign b4_nxt   = q100y3_r + 3'(r100y >= 17'(DAYS_PER_100Y));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh4_r   <= hh3_r;
      rem4_r  <= rem3_r;
      mq0_r   <= mq0_nxt;
      wd4_r   <= wd3_r;
      era4_r  <= era3_r;
      doe4_r  <= doe3_r;
      a4_r    <= a4_nxt;
      b4_r    <= b4_nxt;
      last4_r <= last3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: fix minute, seconds; leap-corrected day count for the year.
  // --------------------------------------------------------------------------
  tod_t        tod_r [5:LAST-1];
  tod_t        tod5_nxt;
  logic        era5_r;
  logic [17:0] doe5_r;
  logic [17:0] num5_r, num5_nxt;
  logic [6:0]  mr_raw;
  logic        mr_fix;
  logic [6:0]  mi_full;

  assign mr_raw       = 7'(rem4_r - 12'(mq0_r) * 12'(SEC_PER_MIN));
  assign mr_fix       = mr_raw >= 7'(SEC_PER_MIN);
  assign mi_full      = mq0_r + 7'(mr_fix);
  assign tod5_nxt.hh  = hh4_r;
  assign tod5_nxt.mi  = mi_full[5:0];
  assign tod5_nxt.ss  = 6'(mr_fix ? mr_raw - 7'(SEC_PER_MIN) : mr_raw);
  assign tod5_nxt.wd  = wd4_r;
  assign num5_nxt     = doe4_r - 18'(a4_r) + 18'(b4_r) - 18'(last4_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tod_r[5] <= tod5_nxt;
      era5_r   <= era4_r;
      doe5_r   <= doe4_r;
      num5_r   <= num5_nxt;
    end
  end

  // time-of-day fields ride along with the date stages
  for (genvar g = 6; g <= LAST - 1; g++) begin : g_tod
    always_ff @(posedge clk) begin
      if (en[g]) begin
        tod_r[g] <= tod_r[g-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: year-of-era estimate.
  // --------------------------------------------------------------------------
  logic        era6_r;
  logic [17:0] doe6_r;
  logic [17:0] num6_r;
  logic [8:0]  yq0_r, yq0_nxt;
  logic [27:0] year_prod;

  assign year_prod = 28'(num5_r) * 28'(YEAR_RCP);
  assign yq0_nxt   = year_prod[26:18];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      era6_r <= era5_r;
      doe6_r <= doe5_r;
      num6_r <= num5_r;
      yq0_r  <= yq0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: fix year of era.
  // --------------------------------------------------------------------------
  logic        era7_r;
  logic [17:0] doe7_r;
  logic [8:0]  yoe7_r, yoe7_nxt;
  logic [9:0]  yr_raw;

  assign yr_raw   = 10'(num6_r - 18'(yq0_r) * 18'(DAYS_PER_YEAR));
  assign yoe7_nxt = yq0_r + 9'(yr_raw >= 10'(DAYS_PER_YEAR));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      era7_r <= era6_r;
      doe7_r <= doe6_r;
      yoe7_r <= yoe7_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: days before this year of era; March-based year.
  // --------------------------------------------------------------------------
  logic [17:0] doe8_r;
  logic [17:0] sub8_r, sub8_nxt;
  logic [11:0] y8_r, y8_nxt;
  logic [1:0]  cent;

  always_comb begin
    if (yoe7_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe7_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe7_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  assign sub8_nxt = 18'(yoe7_r) * 18'(DAYS_PER_YEAR) + 18'(yoe7_r[8:2]) - 18'(cent);
  assign y8_nxt   = 12'(yoe7_r) + (era7_r ? 12'(YEAR_ERA5) : 12'(YEAR_ERA4));

  always_ff @(posedge clk) begin
    if (en[8]) begin
      doe8_r <= doe7_r;
      sub8_r <= sub8_nxt;
      y8_r   <= y8_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: day of year (March-based).
  // --------------------------------------------------------------------------
  logic [8:0]  doy9_r, doy9_nxt;
  logic [11:0] y9_r;

  assign doy9_nxt = 9'(doe8_r - sub8_r);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      doy9_r <= doy9_nxt;
      y9_r   <= y8_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: month estimate from (5 * doy + 2) / 153.
  // --------------------------------------------------------------------------
  logic [8:0]  doy10_r;
  logic [11:0] y10_r;
  logic [10:0] x10_r, x10_nxt;
  logic [3:0]  mpq10_r, mpq10_nxt;
  logic [14:0] mp_prod;

  assign x10_nxt   = 11'(doy9_r) * 11'(5) + 11'(2);
  assign mp_prod   = 15'(x10_nxt) * 15'(MP_RCP);
  assign mpq10_nxt = mp_prod[14:11];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      doy10_r <= doy9_r;
      y10_r   <= y9_r;
      x10_r   <= x10_nxt;
      mpq10_r <= mpq10_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: fix March-based month.
  // --------------------------------------------------------------------------
  logic [8:0]  doy11_r;
  logic [11:0] y11_r;
  logic [3:0]  mp11_r, mp11_nxt;
  logic [8:0]  mpr_raw;

  assign mpr_raw  = 9'(x10_r - 11'(mpq10_r) * 11'(MP_DAYS));
  assign mp11_nxt = mpq10_r + 4'(mpr_raw >= 9'(MP_DAYS));

  always_ff @(posedge clk) begin
    if (en[11]) begin
      doy11_r <= doy10_r;
      y11_r   <= y10_r;
      mp11_r  <= mp11_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: day of month, civil month, civil year.
  // --------------------------------------------------------------------------
  logic [4:0]  dd12_r, dd12_nxt;
  logic [3:0]  mm12_r, mm12_nxt;
  logic [11:0] year12_r, year12_nxt;
  logic        jan_feb;

  assign jan_feb    = mp11_r >= 4'(MONTHS_WRAP);
  assign dd12_nxt   = 5'(doy11_r - month_start(mp11_r) + 9'd1);
  assign mm12_nxt   = jan_feb ? mp11_r - 4'd9 : mp11_r + 4'd3;
  assign year12_nxt = y11_r + 12'(jan_feb);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      dd12_r   <= dd12_nxt;
      mm12_r   <= mm12_nxt;
      year12_r <= year12_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: two-digit year and range flag (years span 1970..2106).
  // --------------------------------------------------------------------------
  logic [4:0] dd13_r;
  logic [3:0] mm13_r;
  logic [6:0] yy13_r, yy13_nxt;
  logic       oor13_r, oor13_nxt;
  logic [7:0] ycent;

  assign ycent     = 8'(year12_r - 12'(YEAR_CENTURY));
  assign yy13_nxt  = 7'((ycent >= 8'd200) ? ycent - 8'd200 :
                        (ycent >= 8'd100) ? ycent - 8'd100 : ycent);
  assign oor13_nxt = (year12_r < 12'(YEAR_MIN)) || (year12_r > 12'(YEAR_MAX));

  always_ff @(posedge clk) begin
    if (en[13]) begin
      dd13_r  <= dd12_r;
      mm13_r  <= mm12_r;
      yy13_r  <= yy13_nxt;
      oor13_r <= oor13_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 14: BCD packing into the output register.
  // --------------------------------------------------------------------------
  logic [7:0] sec_bcd, min_bcd, hour_bcd, day_bcd, mon_bcd, yr_bcd;
  logic [6:0] sec_r;
  logic [6:0] min_r;
  logic [5:0] hour_r;
  logic [2:0] wday_r, wday_nxt;
  logic [5:0] day_r;
  logic [4:0] mon_r;
  logic [7:0] yr_r;
  logic       oor_r;

  assign sec_bcd  = bin2bcd(7'(tod_r[LAST-1].ss));
  assign min_bcd  = bin2bcd(7'(tod_r[LAST-1].mi));
  assign hour_bcd = bin2bcd(7'(tod_r[LAST-1].hh));
  assign day_bcd  = bin2bcd(7'(dd13_r));
  assign mon_bcd  = bin2bcd(7'(mm13_r));
  assign yr_bcd   = bin2bcd(yy13_r);
  assign wday_nxt = tod_r[LAST-1].wd + 3'd1;

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      sec_r  <= sec_bcd[6:0];
      min_r  <= min_bcd[6:0];
      hour_r <= hour_bcd[5:0];
      wday_r <= wday_nxt;
      day_r  <= day_bcd[5:0];
      mon_r  <= mon_bcd[4:0];
      yr_r   <= yr_bcd;
      oor_r  <= oor13_r;
    end
  end

  assign out_tdata = {5'b0, oor_r, yr_r, mon_r, day_r, wday_r, hour_r, min_r, sec_r};

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `CHK_NEXT(a_entry_valid, in_tvalid && in_tready, v_r[0], "accepted beat not captured")
  `CHK_ALWAYS(a_sod_range, v_r[1] |-> (sod1_r < 17'(SEC_PER_DAY)), "seconds of day out of range")
  `CHK_ALWAYS(a_mp_range, v_r[11] |-> (mp11_r < 4'd12), "March-based month out of range")
  `CHK_ALWAYS(a_wday_nonzero, v_r[LAST] |-> (wday_r != 3'd0), "weekday zero at output")

endmodule

// ----- dv/calendar_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both streams of the Unix time to BCD calendar converter, predicts
// the calendar fields of every accepted timestamp and compares each output
// beat, field by field and in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          errors,
  output int          pending,
  output int          dates_checked
);

  // Laid out as on out_tdata, highest field first.
  typedef struct packed {
    logic [4:0] pad;
    logic       year_oor;
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [6:0] second_bcd;
  } calendar_t;

  calendar_t pending_dates [$];

  function automatic logic [7:0] two_digit_bcd(input int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // Days since epoch -> civil date on 400-year eras starting at 0000-03-01.
  function automatic calendar_t civil_from_unix(input logic [31:0] ts);
    int unsigned days, sod, z, era, doe, yoe, doy, mp, dd, mm, yr;
    calendar_t   c;
    days = ts / 86400;
    sod  = ts % 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mm   = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
    c.pad        = '0;
    c.year_oor   = (yr < 2000 || yr > 2099);
    c.year_bcd   = two_digit_bcd((yr + 100 - 2000) % 100);
    c.month_bcd  = 5'(two_digit_bcd(mm));
    c.day_bcd    = 6'(two_digit_bcd(dd));
    c.weekday    = 3'((days + 4) % 7 + 1);
    c.hour_bcd   = 6'(two_digit_bcd(sod / 3600));
    c.minute_bcd = 7'(two_digit_bcd((sod % 3600) / 60));
    c.second_bcd = 7'(two_digit_bcd(sod % 60));
    return c;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %02h, got %02h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors        = 0;
    pending       = 0;
    dates_checked = 0;
  end

  always @(posedge clk) begin
    calendar_t exp_c, act_c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        act_c = out_tdata;
        if (pending_dates.size() == 0) begin
          $error("output beat %012h with no timestamp outstanding", out_tdata);
          errors++;
        end else begin
          exp_c = pending_dates.pop_front();
          compare_field("second_bcd", 8'(exp_c.second_bcd), 8'(act_c.second_bcd));
          compare_field("minute_bcd", 8'(exp_c.minute_bcd), 8'(act_c.minute_bcd));
          compare_field("hour_bcd", 8'(exp_c.hour_bcd), 8'(act_c.hour_bcd));
          compare_field("weekday", 8'(exp_c.weekday), 8'(act_c.weekday));
          compare_field("day_bcd", 8'(exp_c.day_bcd), 8'(act_c.day_bcd));
          compare_field("month_bcd", 8'(exp_c.month_bcd), 8'(act_c.month_bcd));
          compare_field("year_bcd", exp_c.year_bcd, act_c.year_bcd);
          compare_field("year_out_of_range", 8'(exp_c.year_oor), 8'(act_c.year_oor));
          compare_field("pad", 8'(exp_c.pad), 8'(act_c.pad));
          dates_checked++;
        end
      end
      if (in_tvalid && in_tready)
        pending_dates.push_back(civil_from_unix(in_tdata));
      pending = pending_dates.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for unix_time_to_bcd_calendar. A directed set hits the
// epoch, the top of the 32-bit range, both ends of 2000..2099, leap and
// non-leap February ends, every weekday and time-of-day rollovers; a random
// set mixes full-range stamps with stamps clustered on day, minute and
// century edges. Bursty input and a shifting output stall pattern exercise
// the pipeline's flow control; calendar_checker does all the comparing.
// ----------------------------------------------------------------------------
module testbench
  import ut2bcd_pkg::*;
();

  localparam int RANDOM_BEATS = 1925;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] unix_seconds
  logic        out_tvalid;
  logic        out_tready;
  // [6:0] second_bcd, [13:7] minute_bcd, [19:14] hour_bcd, [22:20] weekday,
  // [28:23] day_bcd, [33:29] month_bcd, [41:34] year_bcd,
  // [42] year_out_of_range, [47:43] zero
  logic [47:0] out_tdata;

  int errors;
  int pending;
  int dates_checked;
  int cycles;
  int burst_left;
  int directed_sent;
  int random_sent;

  // Stall pattern state for the output side.
  int stall_mode;
  int stall_left;
  int stall_phase;

  logic [31:0] edge_stamps [$];

  unix_time_to_bcd_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  calendar_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .errors        (errors),
    .pending       (pending),
    .dates_checked (dates_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output stall pattern: switches at random between
  // always-ready, mostly-ready, mostly-stalled and a fixed duty cycle.
  initial begin
    stall_mode  = 0;
    stall_left  = 0;
    stall_phase = 0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 300);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= ((stall_phase % 11) < 4);
      end
    endcase
  end

  // One input beat: hold valid/data until the handshake edge. in_tready is
  // looked at on the falling edge, where nothing is changing.
  task automatic push_timestamp(input logic [31:0] ts);
    int gap;
    if (burst_left == 0) begin
      // New burst; now and then a long one with no gaps at all.
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 12);
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ts;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Random stamp, weighted toward the places where carries ripple.
  function automatic logic [31:0] pick_stamp();
    logic [31:0] anchor;
    int          kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        anchor = $urandom;
      end
      4, 5: begin
        // near a century edge, a leap day, or either end of the range
        case ($urandom_range(0, 5))
          0:       anchor = 32'd946684800;    // 2000-01-01
          1:       anchor = 32'd4102444800;   // 2100-01-01
          2:       anchor = 32'd4107542400;   // 2100-03-01, no Feb 29
          3:       anchor = 32'd951868800;    // 2000-03-01, after Feb 29
          4:       anchor = 32'hFFFFFFFF;
          default: anchor = 32'd0;
        endcase
        anchor = anchor + 32'($urandom_range(0, 400000)) - 32'd200000;
      end
      6, 7: begin
        // midnight, give or take a few seconds
        anchor = 32'($urandom_range(0, 49710)) * 32'd86400
               + 32'($urandom_range(0, 6)) - 32'd3;
      end
      default: begin
        // minute rollover
        anchor = ($urandom / 60) * 60 + 32'($urandom_range(0, 2)) - 32'd1;
      end
    endcase
    return anchor;
  endfunction

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    burst_left = 0;
    directed_sent = 0;
    random_sent   = 0;

    edge_stamps = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      // noon on days 2..6: Saturday through Wednesday
      32'd216000, 32'd302400, 32'd388800, 32'd475200, 32'd561600,
      32'd946684799,   // 1999-12-31 23:59:59, last out-of-range low year
      32'd946684800,   // 2000-01-01
      32'd951825600,   // 2000-02-29 noon
      32'd978307199,   // 2000-12-31 23:59:59
      32'd1709164800,  // 2024-02-29
      32'd4102444799,  // 2099-12-31 23:59:59
      32'd4102444800,  // 2100-01-01, first out-of-range high year
      32'd4107542399,  // 2100-02-28 23:59:59
      32'd4107542400,  // 2100-03-01
      32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_stamps[i]) begin
      push_timestamp(edge_stamps[i]);
      directed_sent++;
    end

    repeat (RANDOM_BEATS) begin
      push_timestamp(pick_stamp());
      random_sent++;
    end
    in_tvalid <= 1'b0;

    // Drain, then give the pipeline room to show any stray beat. Wait on the
    // clock first so the checker has counted the last beat taken.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);

    $display("Converted %0d timestamps (%0d edge cases, %0d random) under bursty input",
             directed_sent + random_sent, directed_sent, random_sent);
    $display("and shifting output stalls; %0d dates compared, %0d field mismatches.",
             dates_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- unix_time_to_bcd_calendar.f -----
+incdir+rtl
rtl/ut2bcd_pkg.sv
rtl/unix_time_to_bcd_calendar.sv
dv/calendar_checker.sv
dv/testbench.sv
